// File: sv/mwm_pkg.sv
// Package with the constants, widths and sine table of the mecanum wheel mixer.
package mwm_pkg;

  localparam int unsigned HEADING_W = 9;
  localparam int unsigned MAG_W     = 7;
  localparam int unsigned DUTY_W    = 8;

  // Full scale of the duty value that the parameter may take.
  localparam int unsigned SCALE_W         = 16;
  localparam int unsigned DUTY_MAX_DEFAULT = 255;

  localparam logic [HEADING_W-1:0] DEG_FULL    = 9'd360;
  localparam logic [HEADING_W-1:0] DEG_HALF    = 9'd180;
  localparam logic [HEADING_W-1:0] DEG_QUARTER = 9'd90;
  localparam logic [HEADING_W-1:0] DEG_3QUART  = 9'd270;

  localparam int unsigned TRIG_W    = 16;  // signed Q1.14 value, -16384..16384
  localparam int unsigned PROD_W    = 22;  // signed trig times magnitude
  localparam int unsigned SPEED_W   = 23;  // signed sum or difference
  localparam int unsigned ABS_W     = 22;  // magnitude of a wheel speed
  localparam int unsigned SCALED_W  = ABS_W + SCALE_W;
  localparam int unsigned LOW_SHIFT = 16;  // the scale 1638400 is 2^16 * 25

  // Exact floor division by 25 for values below 2^22: multiply and shift.
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP_25 = 23'd5368710;
  localparam int unsigned QPROD_W = ABS_W + RECIP_W;
  localparam int unsigned QUOT_W  = QPROD_W - RECIP_SHIFT;

  localparam int unsigned NUM_STAGES = 7;
  localparam int unsigned NUM_LANES  = 2;  // lane 0 is y+x, lane 1 is y-x

  // round(sin(k degrees) * 16384) for k = 0..90.
  localparam logic [14:0] QUARTER_SINE [91] = '{
        15'd0,   15'd286,   15'd572,   15'd857,  15'd1143,  15'd1428,  15'd1713,
     15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
     15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
     15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
     15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
     15'd9397,  15'd9630,  15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sine in signed Q1.14 of an angle already reduced to 0..359 degrees.
  function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [HEADING_W-1:0] deg);
    logic [HEADING_W-1:0] idx;
    logic                 neg;
    logic [TRIG_W-1:0]    mag;
    if (deg <= DEG_QUARTER) begin
      idx = deg;
      neg = 1'b0;
    end else if (deg <= DEG_HALF) begin
      idx = DEG_HALF - deg;
      neg = 1'b0;
    end else if (deg <= DEG_3QUART) begin
      idx = deg - DEG_HALF;
      neg = 1'b1;
    end else begin
      idx = DEG_FULL - deg;
      neg = 1'b1;
    end
    mag = {1'b0, QUARTER_SINE[idx[6:0]]};
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

// File: sv/mecanum_wheel_mixer.sv
// Mecanum wheel mixer: heading and magnitude in, four wheel duties and directions out.
// Throughput is one word per cycle; the pipeline moves as one and halts only
// while a finished word waits at the output under out_stall_i.
// The active-low asynchronous reset clears every stage's valid bit; data
// registers are not reset. The block keeps no state between words.
module mecanum_wheel_mixer #(
  parameter int unsigned DUTY_MAX = mwm_pkg::DUTY_MAX_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mwm_pkg::HEADING_W-1:0] heading_deg_i,
  input  logic [mwm_pkg::MAG_W-1:0]     magnitude_pct_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mwm_pkg::DUTY_W-1:0]    front_left_duty_o,
  output logic                         front_left_reverse_o,
  output logic [mwm_pkg::DUTY_W-1:0]    front_right_duty_o,
  output logic                         front_right_reverse_o,
  output logic [mwm_pkg::DUTY_W-1:0]    rear_left_duty_o,
  output logic                         rear_left_reverse_o,
  output logic [mwm_pkg::DUTY_W-1:0]    rear_right_duty_o,
  output logic                         rear_right_reverse_o
);
  import mwm_pkg::*;

  // The duty limit scales every wheel speed, so it must fit the scale multiplier.
  localparam logic [SCALE_W-1:0] DutyMaxK = SCALE_W'(DUTY_MAX);

  // One valid bit per stage; the last one qualifies the output word.
  logic [NUM_STAGES-1:0] valid_q;
  logic                  advance;

  // Stage 1: heading reduced modulo 360, and the cosine angle beside it.
  logic [HEADING_W-1:0] deg_d, cdeg_d, deg_q, cdeg_q;
  logic [MAG_W-1:0]     mag1_q, mag2_q;

  // Stage 2: sine and cosine from the quarter-wave table.
  logic signed [TRIG_W-1:0] sin_q, cos_q;

  // Stage 3: x and y, scaled by 16384 * 100, held exactly.
  logic signed [PROD_W-1:0] sx_d, sy_d, sx_q, sy_q;

  // Stage 4 onward: two lanes, since front-left equals rear-right and
  // front-right equals rear-left.
  logic signed [SPEED_W-1:0] speed_d [NUM_LANES];
  logic [ABS_W-1:0]          abs_d [NUM_LANES];
  logic [ABS_W-1:0]          abs_q [NUM_LANES];
  logic [SCALED_W-1:0]       scaled_d [NUM_LANES];
  logic [ABS_W-1:0]          scaled_q [NUM_LANES];
  logic [QPROD_W-1:0]        qprod_d [NUM_LANES];
  logic [QUOT_W-1:0]         quot_q [NUM_LANES];
  logic [QUOT_W-1:0]         sat_d [NUM_LANES];
  logic [DUTY_W-1:0]         duty_q [NUM_LANES];
  logic [NUM_LANES-1:0]      rev4_q, rev5_q, rev6_q, rev7_q;

  // The whole pipe steps unless a finished word is held at the output.
  assign advance    = !valid_q[NUM_STAGES-1] || !out_stall_i;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  always_comb begin
    deg_d  = (heading_deg_i >= DEG_FULL) ? heading_deg_i - DEG_FULL : heading_deg_i;
    cdeg_d = (deg_d >= DEG_3QUART) ? deg_d - DEG_3QUART : deg_d + DEG_QUARTER;
  end

  assign sx_d = PROD_W'(cos_q * $signed({1'b0, mag2_q}));
  assign sy_d = PROD_W'(sin_q * $signed({1'b0, mag2_q}));

  always_comb begin
    speed_d[0] = SPEED_W'(sy_q) + SPEED_W'(sx_q);
    speed_d[1] = SPEED_W'(sy_q) - SPEED_W'(sx_q);
    for (int l = 0; l < NUM_LANES; l++) begin
      abs_d[l]    = speed_d[l][SPEED_W-1] ? ABS_W'(-speed_d[l]) : ABS_W'(speed_d[l]);
      // The scale 16384 * 100 splits into a shift by 16 and a divide by 25.
      scaled_d[l] = SCALED_W'(abs_q[l]) * SCALED_W'(DutyMaxK);
      qprod_d[l]  = QPROD_W'(scaled_q[l]) * QPROD_W'(RECIP_25);
      sat_d[l]    = (quot_q[l] > QUOT_W'(DutyMaxK)) ? QUOT_W'(DutyMaxK) : quot_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      deg_q  <= deg_d;
      cdeg_q <= cdeg_d;
      mag1_q <= magnitude_pct_i;
      sin_q  <= sine_q14(deg_q);
      cos_q  <= sine_q14(cdeg_q);
      mag2_q <= mag1_q;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      for (int l = 0; l < NUM_LANES; l++) begin
        abs_q[l]    <= abs_d[l];
        rev4_q[l]   <= speed_d[l][SPEED_W-1];
        scaled_q[l] <= scaled_d[l][SCALED_W-1:LOW_SHIFT];
        quot_q[l]   <= qprod_d[l][QPROD_W-1:RECIP_SHIFT];
        // Duty is masked to the field width when the limit exceeds it.
        duty_q[l]   <= sat_d[l][DUTY_W-1:0];
      end
      rev5_q <= rev4_q;
      rev6_q <= rev5_q;
      rev7_q <= rev6_q;
    end
  end

  assign out_valid_o           = valid_q[NUM_STAGES-1];
  assign front_left_duty_o     = duty_q[0];
  assign front_left_reverse_o  = rev7_q[0];
  assign rear_right_duty_o     = duty_q[0];
  assign rear_right_reverse_o  = rev7_q[0];
  assign front_right_duty_o    = duty_q[1];
  assign front_right_reverse_o = rev7_q[1];
  assign rear_left_duty_o      = duty_q[1];
  assign rear_left_reverse_o   = rev7_q[1];

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the mecanum wheel mixer with random idling and output stalls.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mwm_pkg::*;

  // Wheel output duty is scaled by this full-scale value.
  localparam int unsigned DUTY_MAX = 255;
  // The block holds trig values scaled by 16384 and magnitudes by 100.
  localparam longint SPEED_SCALE = 64'd1638400;
  // Generous limit for about 1500 words with random idling and output stalls.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // The pipeline is seven stages deep, so this many quiet cycles at the end
  // are plenty for a stray word to show up.
  localparam int unsigned DRAIN_CYCLES = 20;
  // Long output hold-off, in cycles, that fills the pipeline and stalls the input.
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;

  // Quarter-wave sine in Q1.14, round(sin(k degrees) * 16384) for k = 0..90.
  localparam int SINE_Q14 [91] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // Idling pattern of the two channels during a stretch of the run.
  typedef enum logic [1:0] {
    PH_STEADY,
    PH_TX_GAPS,
    PH_RX_STALLS,
    PH_BOTH_IDLE
  } phase_e;

  // One drive command waiting to be offered to the block.
  typedef struct {
    logic [HEADING_W-1:0] heading;
    logic [MAG_W-1:0]     pct;
    phase_e               phase;
  } drive_cmd_t;

  // The four wheel settings carried by one output word.
  typedef struct packed {
    logic [DUTY_W-1:0] fl_duty;
    logic              fl_rev;
    logic [DUTY_W-1:0] fr_duty;
    logic              fr_rev;
    logic [DUTY_W-1:0] rl_duty;
    logic              rl_rev;
    logic [DUTY_W-1:0] rr_duty;
    logic              rr_rev;
  } wheel_set_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  logic [HEADING_W-1:0] heading = '0;
  logic [MAG_W-1:0]     pct = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  wheel_set_t           got;

  drive_cmd_t  pending_cmds [$];
  wheel_set_t  expected_wheels [$];
  drive_cmd_t  next_cmd;
  phase_e      cur_phase = PH_STEADY;
  logic        hold_off = 1'b0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;

  mecanum_wheel_mixer #(
    .DUTY_MAX(DUTY_MAX)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall_o),
    .heading_deg_i        (heading),
    .magnitude_pct_i      (pct),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall),
    .front_left_duty_o    (got.fl_duty),
    .front_left_reverse_o (got.fl_rev),
    .front_right_duty_o   (got.fr_duty),
    .front_right_reverse_o(got.fr_rev),
    .rear_left_duty_o     (got.rl_duty),
    .rear_left_reverse_o  (got.rl_rev),
    .rear_right_duty_o    (got.rr_duty),
    .rear_right_reverse_o (got.rr_rev)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sine of an angle already reduced to 0..359 degrees, folded onto the
  // quarter-wave table.
  function automatic longint sine_of(input int unsigned deg);
    if (deg <= 90) begin
      return SINE_Q14[deg];
    end else if (deg <= 180) begin
      return SINE_Q14[180 - deg];
    end else if (deg <= 270) begin
      return -SINE_Q14[deg - 180];
    end
    return -SINE_Q14[360 - deg];
  endfunction

  // Duty and direction of one wheel. The speed carries the 16384*100 scale,
  // so the duty is floor(|speed| * DUTY_MAX / scale), clipped at DUTY_MAX.
  // A speed of exactly zero runs forward.
  function automatic void wheel_drive(input longint speed, output logic [DUTY_W-1:0] duty,
                                      output logic rev);
    longint mag;
    longint d;
    rev = (speed < 0);
    mag = rev ? -speed : speed;
    d = (mag * DUTY_MAX) / SPEED_SCALE;
    if (d > DUTY_MAX) begin
      d = DUTY_MAX;
    end
    duty = d[DUTY_W-1:0];
  endfunction

  // Mecanum mixing: x = cos*m, y = sin*m; front-left and rear-right take y+x,
  // front-right and rear-left take y-x. Headings past 359 wrap around the circle
  // and magnitudes past 100 are used as they are.
  function automatic wheel_set_t mix_wheels(input logic [HEADING_W-1:0] hdg,
                                            input logic [MAG_W-1:0] m);
    wheel_set_t   w;
    int unsigned  deg;
    longint       sx;
    longint       sy;
    deg = int'(hdg) % 360;
    sx = sine_of((deg + 90) % 360) * longint'(m);
    sy = sine_of(deg) * longint'(m);
    wheel_drive(sy + sx, w.fl_duty, w.fl_rev);
    wheel_drive(sy - sx, w.fr_duty, w.fr_rev);
    wheel_drive(sy - sx, w.rl_duty, w.rl_rev);
    wheel_drive(sy + sx, w.rr_duty, w.rr_rev);
    return w;
  endfunction

  function automatic int unsigned tx_idle_pct(input phase_e ph);
    case (ph)
      PH_TX_GAPS:   return 47;
      PH_BOTH_IDLE: return 37;
      default:      return 0;
    endcase
  endfunction

  function automatic int unsigned rx_stall_pct(input phase_e ph);
    case (ph)
      PH_RX_STALLS: return 47;
      PH_BOTH_IDLE: return 37;
      default:      return 0;
    endcase
  endfunction

  task automatic add_cmd(input int unsigned hdg, input int unsigned m, input phase_e ph);
    drive_cmd_t c;
    c.heading = hdg[HEADING_W-1:0];
    c.pct     = m[MAG_W-1:0];
    c.phase   = ph;
    pending_cmds.push_back(c);
  endtask

  // Random command: mostly legal joystick values, with a share of the full
  // field range so that wrapped headings and oversized magnitudes turn up.
  task automatic add_random_cmd(input phase_e ph);
    int unsigned h;
    int unsigned m;
    int unsigned pick;
    h = ($urandom_range(99) < 75) ? $urandom_range(359) : $urandom_range(511);
    pick = $urandom_range(99);
    if (pick < 10) begin
      m = 0;
    end else if (pick < 20) begin
      m = 100;
    end else if (pick < 80) begin
      m = $urandom_range(100);
    end else begin
      m = $urandom_range(127);
    end
    add_cmd(h, m, ph);
  endtask

  // Driver. A word is taken when valid is high and the block is not stalling.
  // The next word goes out only once the current one has been taken, so a
  // stalled word holds still; whether to idle is decided without looking at
  // the stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_wheels.push_back(mix_wheels(heading, pct));
        n_accepted++;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_cmds.size() > 0 &&
            $urandom_range(99) >= tx_idle_pct(pending_cmds[0].phase)) begin
          next_cmd = pending_cmds.pop_front();
          in_valid  <= 1'b1;
          heading   <= next_cmd.heading;
          pct       <= next_cmd.pct;
          cur_phase <= next_cmd.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each word that leaves the block is compared field by field with
  // the oldest outstanding prediction; the stall for the next cycle follows
  // the current idling pattern unless a long hold-off is in progress.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_wheels.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("tb_top: unexpected output word at cycle %0d", n_cycles);
          end
        end else begin
          if (got.fl_duty !== expected_wheels[0].fl_duty ||
              got.fl_rev  !== expected_wheels[0].fl_rev  ||
              got.fr_duty !== expected_wheels[0].fr_duty ||
              got.fr_rev  !== expected_wheels[0].fr_rev  ||
              got.rl_duty !== expected_wheels[0].rl_duty ||
              got.rl_rev  !== expected_wheels[0].rl_rev  ||
              got.rr_duty !== expected_wheels[0].rr_duty ||
              got.rr_rev  !== expected_wheels[0].rr_rev) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("tb_top: word %0d mismatch, expected FL %0d/%0b FR %0d/%0b RL %0d/%0b RR %0d/%0b",
                       n_checked,
                       expected_wheels[0].fl_duty, expected_wheels[0].fl_rev,
                       expected_wheels[0].fr_duty, expected_wheels[0].fr_rev,
                       expected_wheels[0].rl_duty, expected_wheels[0].rl_rev,
                       expected_wheels[0].rr_duty, expected_wheels[0].rr_rev);
              $display("tb_top:   actual FL %0d/%0b FR %0d/%0b RL %0d/%0b RR %0d/%0b",
                       got.fl_duty, got.fl_rev, got.fr_duty, got.fr_rev,
                       got.rl_duty, got.rl_rev, got.rr_duty, got.rr_rev);
            end
          end
          void'(expected_wheels.pop_front());
          n_checked++;
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct(cur_phase));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", n_cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Long output hold-off early in the steady stretch, while the driver keeps
  // offering words: the pipeline fills and the input must stall.
  initial begin
    wait (n_accepted >= 150);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    // Directed words: axis headings, the diagonals where one wheel pair
    // cancels to exactly zero, zero magnitude, the largest heading and
    // magnitude codes, and headings that wrap past a full turn.
    add_cmd(0, 100, PH_STEADY);
    add_cmd(90, 100, PH_STEADY);
    add_cmd(180, 100, PH_STEADY);
    add_cmd(270, 100, PH_STEADY);
    add_cmd(359, 100, PH_STEADY);
    add_cmd(45, 100, PH_STEADY);
    add_cmd(135, 100, PH_STEADY);
    add_cmd(225, 100, PH_STEADY);
    add_cmd(315, 100, PH_STEADY);
    add_cmd(0, 0, PH_STEADY);
    add_cmd(200, 0, PH_STEADY);
    add_cmd(511, 0, PH_STEADY);
    add_cmd(1, 1, PH_STEADY);
    add_cmd(179, 1, PH_STEADY);
    add_cmd(360, 100, PH_STEADY);
    add_cmd(405, 100, PH_STEADY);
    add_cmd(450, 73, PH_STEADY);
    add_cmd(511, 127, PH_STEADY);
    add_cmd(0, 127, PH_STEADY);
    add_cmd(45, 101, PH_STEADY);
    add_cmd(256, 64, PH_STEADY);
    add_cmd(30, 50, PH_STEADY);
    add_cmd(300, 99, PH_STEADY);
    add_cmd(170, 127, PH_STEADY);
    add_cmd(91, 85, PH_STEADY);
    // Random words in four stretches of idling.
    repeat (450) add_random_cmd(PH_STEADY);
    repeat (350) add_random_cmd(PH_TX_GAPS);
    repeat (350) add_random_cmd(PH_RX_STALLS);
    repeat (350) add_random_cmd(PH_BOTH_IDLE);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_cmds.size() == 0 && !in_valid);
    wait (expected_wheels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_wheels.size() != 0) begin
      n_errors++;
      $display("tb_top: %0d predicted words never came out", expected_wheels.size());
    end

    $display("tb_top: %0d drive commands sent, %0d wheel words compared, %0d mismatches",
             n_accepted, n_checked, n_errors);
    $display("tb_top: covered steady flow, input gaps, output stalls, both, and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: mecanum_wheel_mixer.f
sv/mwm_pkg.sv
sv/mecanum_wheel_mixer.sv
bench/tb_top.sv
